// ===== rtl/scfb_pkg.sv =====
// Shared types and constants for the sonar command frame builder.
// No dependencies; every other file in rtl/ uses this package.
package scfb_pkg;

    localparam int FRAME_LEN = 27;
    localparam int IDX_W     = 5;

    // Byte positions within the frame
    localparam logic [IDX_W-1:0] IDX_SYNC0  = 5'd0;
    localparam logic [IDX_W-1:0] IDX_SYNC1  = 5'd1;
    localparam logic [IDX_W-1:0] IDX_SYNC2  = 5'd2;
    localparam logic [IDX_W-1:0] IDX_RANGE  = 5'd3;
    localparam logic [IDX_W-1:0] IDX_REV    = 5'd5;
    localparam logic [IDX_W-1:0] IDX_GAIN   = 5'd8;
    localparam logic [IDX_W-1:0] IDX_ABSORB = 5'd10;
    localparam logic [IDX_W-1:0] IDX_ANGLE  = 5'd11;
    localparam logic [IDX_W-1:0] IDX_SECTOR = 5'd12;
    localparam logic [IDX_W-1:0] IDX_STEP   = 5'd13;
    localparam logic [IDX_W-1:0] IDX_SLEN   = 5'd14;
    localparam logic [IDX_W-1:0] IDX_DPTS   = 5'd19;
    localparam logic [IDX_W-1:0] IDX_SWDLY  = 5'd24;
    localparam logic [IDX_W-1:0] IDX_FREQ   = 5'd25;
    localparam logic [IDX_W-1:0] IDX_LAST   = 5'd26;

    // Fixed byte values
    localparam logic [7:0] SYNC0_BYTE  = 8'hFE;
    localparam logic [7:0] SYNC1_BYTE  = 8'h44;
    localparam logic [7:0] SYNC2_BYTE  = 8'h10;
    localparam logic [7:0] ABSORB_BYTE = 8'd20;
    localparam logic [7:0] REV_BYTE    = 8'h40;
    localparam logic [7:0] FREQ_BYTE   = 8'd135;
    localparam logic [7:0] TERM_BYTE   = 8'hFD;

    // Encoded settings of one frame, as held in the queue
    typedef struct packed {
        logic [7:0] range_b;
        logic       rev;
        logic [5:0] gain;
        logic [7:0] angle;
        logic [7:0] sector;
        logic [1:0] step;
        logic [7:0] slen;
        logic [5:0] dpts;
        logic [6:0] swdly;
        logic       freq_hit;
    } t_rec;

    // Queue status seen by the top level and the serializer
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== rtl/sonar_command_frame_builder.sv =====
// Top level of the sonar command frame builder.
// Depends on scfb_pkg, scfb_front, scfb_queue and scfb_back.
//
// Usage:
//   Drive the head settings on the i_ field ports and raise start. A request
//   is taken at a rising edge with start high and busy low. Each request
//   produces one 27-byte command frame (FE 44 10 ... FD) on o_frame_byte,
//   with o_byte_index giving the position and o_last_byte marking the FD
//   terminator. o_strobe marks each byte; every byte is on the ports for
//   exactly one cycle and the receiver cannot hold it off.
//   The request is written into the queue at the accepting edge; an idle
//   serializer pops it from there and registers it before the first byte.
//   The serializer emits one byte per cycle; back-to-back frames stream
//   with no gap while the queue holds the next one. The front end
//   encodes a request in the accepting cycle and parks it in a QUEUE_DEPTH
//   entry queue, so busy rises only when that queue is full.
//   Reset (i_rst_n low, synchronous) empties the queue and idles the
//   serializer; no frame is in flight after reset.
module sonar_command_frame_builder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_range_m,
    input  logic        i_reverse,
    input  logic [7:0]  i_init_gain,
    input  logic [9:0]  i_bearing,
    input  logic [10:0] i_sector_code,
    input  logic [7:0]  i_step_sel,
    input  logic [9:0]  i_step_len,
    input  logic [9:0]  i_sample_count,
    input  logic [9:0]  i_sw_delay,
    input  logic [9:0]  i_frequency,
    output logic        o_strobe,
    output logic [7:0]  o_frame_byte,
    output logic [4:0]  o_byte_index,
    output logic        o_last_byte
);

    scfb_pkg::t_rec   enc_rec;
    scfb_pkg::t_rec   q_rec;
    scfb_pkg::t_qstat q_stat;
    logic             push;
    logic             pop;

    // Accept whenever the queue has room
    assign busy = q_stat.full;
    assign push = start && !busy;

    // Encode the settings combinationally in the accepting cycle
    scfb_front u_front (
        .i_range_m      (i_range_m),
        .i_reverse      (i_reverse),
        .i_init_gain    (i_init_gain),
        .i_bearing      (i_bearing),
        .i_sector_code  (i_sector_code),
        .i_step_sel     (i_step_sel),
        .i_step_len     (i_step_len),
        .i_sample_count (i_sample_count),
        .i_sw_delay     (i_sw_delay),
        .i_frequency    (i_frequency),
        .o_rec          (enc_rec)
    );

    // Hold encoded frames until the serializer is free
    scfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (enc_rec),
        .i_pop   (pop),
        .o_rec   (q_rec),
        .o_stat  (q_stat)
    );

    // Stream each frame out one byte per cycle
    scfb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_qstat      (q_stat),
        .i_rec        (q_rec),
        .o_pop        (pop),
        .o_strobe     (o_strobe),
        .o_frame_byte (o_frame_byte),
        .o_byte_index (o_byte_index),
        .o_last_byte  (o_last_byte)
    );

    a_accept_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> !q_stat.empty || o_strobe)
        else $error("accepted request neither queued nor streaming");

endmodule

// ===== rtl/scfb_front.sv =====
// Front end: encodes one set of head settings into a compact frame record.
// Depends on scfb_pkg.
module scfb_front (
    input  logic [7:0]   i_range_m,
    input  logic         i_reverse,
    input  logic [7:0]   i_init_gain,
    input  logic [9:0]   i_bearing,
    input  logic [10:0]  i_sector_code,
    input  logic [7:0]   i_step_sel,
    input  logic [9:0]   i_step_len,
    input  logic [9:0]   i_sample_count,
    input  logic [9:0]   i_sw_delay,
    input  logic [9:0]   i_frequency,
    output scfb_pkg::t_rec o_rec
);

    logic signed [7:0]  gain_s;
    logic signed [9:0]  ang_s;
    logic signed [9:0]  ang_cl;
    logic signed [10:0] ang_sum;
    logic [8:0]         ang_off;
    logic [17:0]        ang_prod;
    logic signed [10:0] sec_s;
    logic [9:0]         sec_u;
    logic [9:0]         sec_red;
    logic signed [9:0]  slen_s;
    logic signed [9:0]  sd_s;

    assign gain_s = signed'(i_init_gain);
    assign ang_s  = signed'(i_bearing);
    assign sec_s  = signed'(i_sector_code);
    assign slen_s = signed'(i_step_len);
    assign sd_s   = signed'(i_sw_delay);

    // Divide by 3 as multiply by 171/512; exact for offsets up to 420
    assign ang_sum  = 11'(ang_cl) + 11'sd210;
    assign ang_off  = ang_sum[8:0];
    assign ang_prod = 18'(ang_off) * 18'd171;
    assign sec_u    = i_sector_code[9:0];

    always_comb begin
        if (ang_s < -10'sd210) begin
            ang_cl = -10'sd210;
        end else if (ang_s > 10'sd210) begin
            ang_cl = 10'sd210;
        end else begin
            ang_cl = ang_s;
        end

        // Sector above 360 is below 1080, so at most two wraps
        if (sec_s < 11'sd0) begin
            sec_red = 10'd0;
        end else if (sec_u > 10'd360) begin
            if (sec_u >= 10'd720) begin
                sec_red = sec_u - 10'd720;
            end else begin
                sec_red = sec_u - 10'd360;
            end
        end else begin
            sec_red = sec_u;
        end
    end

    always_comb begin
        case (i_range_m)
            8'd5, 8'd10, 8'd20, 8'd30, 8'd40, 8'd50: o_rec.range_b = i_range_m;
            default:                                 o_rec.range_b = 8'd5;
        endcase

        o_rec.rev = i_reverse;

        if (gain_s < 8'sd0) begin
            o_rec.gain = 6'd0;
        end else if (gain_s > 8'sd40) begin
            o_rec.gain = 6'd40;
        end else begin
            o_rec.gain = i_init_gain[5:0];
        end

        o_rec.angle  = ang_prod[16:9];
        o_rec.sector = sec_red[7:0];

        case (i_step_sel)
            8'd0:    o_rec.step = 2'd0;
            8'd6:    o_rec.step = 2'd2;
            default: o_rec.step = 2'd1;
        endcase

        if (slen_s < 10'sd1) begin
            o_rec.slen = 8'd1;
        end else if (slen_s > 10'sd255) begin
            o_rec.slen = 8'd255;
        end else begin
            o_rec.slen = i_step_len[7:0];
        end

        o_rec.dpts = (i_sample_count == 10'd250) ? 6'd25 : 6'd50;

        if (sd_s < 10'sd0) begin
            o_rec.swdly = 7'd0;
        end else if (sd_s > 10'sd255 || sd_s == 10'sd253) begin
            o_rec.swdly = 7'd127;
        end else begin
            o_rec.swdly = i_sw_delay[7:1];
        end

        o_rec.freq_hit = (i_frequency == 10'd850);
    end

endmodule

// ===== rtl/scfb_queue.sv =====
// Short register queue of encoded frame records between front end and serializer.
// Depends on scfb_pkg.
module scfb_queue #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  scfb_pkg::t_rec   i_rec,
    input  logic             i_pop,
    output scfb_pkg::t_rec   o_rec,
    output scfb_pkg::t_qstat o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    scfb_pkg::t_rec r_mem [DEPTH];
    logic [AW-1:0]  r_wptr, n_wptr;
    logic [AW-1:0]  r_rptr, n_rptr;
    logic [CW-1:0]  r_count, n_count;

    assign o_stat.full  = (r_count == CNT_FULL);
    assign o_stat.empty = (r_count == '0);
    assign o_rec        = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_rec;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_stat.full && !i_pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_stat.empty))
        else $error("queue read while empty");

endmodule

// ===== rtl/scfb_back.sv =====
// Serializer: pops one frame record and emits its 27 bytes, one per cycle.
// Depends on scfb_pkg.
module scfb_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  scfb_pkg::t_qstat i_qstat,
    input  scfb_pkg::t_rec   i_rec,
    output logic             o_pop,
    output logic             o_strobe,
    output logic [7:0]       o_frame_byte,
    output logic [4:0]       o_byte_index,
    output logic             o_last_byte
);

    logic                              r_active, n_active;
    logic [scfb_pkg::IDX_W-1:0]        r_idx, n_idx;
    scfb_pkg::t_rec                    r_rec;
    logic                              at_last;

    assign at_last = (r_idx == scfb_pkg::IDX_LAST);
    // Take the next record when idle or on the terminator byte
    assign o_pop   = !i_qstat.empty && (!r_active || at_last);

    always_comb begin
        n_active = r_active;
        n_idx    = r_idx;
        if (o_pop) begin
            n_active = 1'b1;
            n_idx    = '0;
        end else if (r_active) begin
            if (at_last) begin
                n_active = 1'b0;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_active <= n_active;
            r_idx    <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_rec;
        end
    end

    always_comb begin
        case (r_idx)
            scfb_pkg::IDX_SYNC0:  o_frame_byte = scfb_pkg::SYNC0_BYTE;
            scfb_pkg::IDX_SYNC1:  o_frame_byte = scfb_pkg::SYNC1_BYTE;
            scfb_pkg::IDX_SYNC2:  o_frame_byte = scfb_pkg::SYNC2_BYTE;
            scfb_pkg::IDX_RANGE:  o_frame_byte = r_rec.range_b;
            scfb_pkg::IDX_REV:    o_frame_byte = r_rec.rev ? scfb_pkg::REV_BYTE : 8'd0;
            scfb_pkg::IDX_GAIN:   o_frame_byte = {2'b00, r_rec.gain};
            scfb_pkg::IDX_ABSORB: o_frame_byte = scfb_pkg::ABSORB_BYTE;
            scfb_pkg::IDX_ANGLE:  o_frame_byte = r_rec.angle;
            scfb_pkg::IDX_SECTOR: o_frame_byte = r_rec.sector;
            scfb_pkg::IDX_STEP:   o_frame_byte = {6'd0, r_rec.step};
            scfb_pkg::IDX_SLEN:   o_frame_byte = r_rec.slen;
            scfb_pkg::IDX_DPTS:   o_frame_byte = {2'b00, r_rec.dpts};
            scfb_pkg::IDX_SWDLY:  o_frame_byte = {1'b0, r_rec.swdly};
            scfb_pkg::IDX_FREQ:   o_frame_byte = r_rec.freq_hit ? scfb_pkg::FREQ_BYTE : 8'd0;
            scfb_pkg::IDX_LAST:   o_frame_byte = scfb_pkg::TERM_BYTE;
            default:              o_frame_byte = 8'd0;
        endcase
    end

    assign o_strobe     = r_active;
    assign o_byte_index = r_idx;
    assign o_last_byte  = r_active && at_last;

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active && !at_last |=> r_active && (r_idx == $past(r_idx) + 1'b1))
        else $error("frame byte index did not advance");

    a_next_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active && at_last && !i_qstat.empty |=> r_active && (r_idx == '0))
        else $error("queued frame did not follow terminator");

endmodule
